// ===== hw/rtl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce and long-press unit.
// Used by bdlp_cfg, bdlp_core and the top level; depends on nothing else.
`default_nettype none

package bdlp_pkg;

  // Field widths.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS = 2'd1;

  // Reset values of the configuration registers, in milliseconds.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd700;

  // Input action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_START  = 1'b1;

  // Button event codes.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // One input item.
  typedef struct packed {
    logic              action;
    logic              pressed_level;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  // Configuration values seen by the core.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdlp_cfg.sv =====
// Configuration register file: debounce time and long-press time.
// Depends on bdlp_pkg for index codes, reset values and cfg_t.
`default_nettype none

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  logic [CFG_W-1:0] debounce_time_r;
  logic [CFG_W-1:0] long_press_time_r;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r   <= DEBOUNCE_RST;
      long_press_time_r <= LONG_PRESS_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IDX_DEBOUNCE:   debounce_time_r   <= wr_data;
        CFG_IDX_LONG_PRESS: long_press_time_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.debounce_time   = debounce_time_r;
  assign cfg.long_press_time = long_press_time_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bdlp_core.sv =====
// Debounce and press-timing state with the per-sample event logic.
// Depends on bdlp_pkg for item_t, cfg_t and event_t.
`default_nettype none

module bdlp_core
  import bdlp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output event_t    button_event
);

  logic              raw_level_r,     raw_level_nxt;
  logic              stable_level_r,  stable_level_nxt;
  logic [TIME_W-1:0] change_time_r,   change_time_nxt;
  logic [TIME_W-1:0] press_time_r,    press_time_nxt;
  logic              long_reported_r, long_reported_nxt;

  logic [TIME_W-1:0] db_elapsed;
  logic [TIME_W-1:0] lp_elapsed;
  logic              settle;
  logic              press_settle;

  // Step logic: a start item loads the state; otherwise restart the debounce time
  // on a raw change, let the stable level follow once settled, then check for a long press.
  always_comb begin
    raw_level_nxt     = raw_level_r;
    stable_level_nxt  = stable_level_r;
    change_time_nxt   = change_time_r;
    press_time_nxt    = press_time_r;
    long_reported_nxt = long_reported_r;
    button_event      = EV_NONE;

    // A raw change makes the elapsed debounce time zero.
    if (item.pressed_level != raw_level_r) begin
      db_elapsed = '0;
    end else begin
      db_elapsed = item.time_ms - change_time_r;
    end
    settle = (stable_level_r != item.pressed_level) &&
             (db_elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time});
    press_settle = settle && item.pressed_level;

    // An accepted press restarts the press time at the current sample.
    if (press_settle) begin
      lp_elapsed = '0;
    end else begin
      lp_elapsed = item.time_ms - press_time_r;
    end

    if (item.action == ACT_START) begin
      raw_level_nxt     = item.pressed_level;
      stable_level_nxt  = item.pressed_level;
      change_time_nxt   = item.time_ms;
      press_time_nxt    = item.time_ms;
      long_reported_nxt = 1'b0;
    end else begin
      raw_level_nxt = item.pressed_level;
      if (item.pressed_level != raw_level_r) begin
        change_time_nxt = item.time_ms;
      end
      if (settle) begin
        stable_level_nxt = item.pressed_level;
        if (item.pressed_level) begin
          press_time_nxt    = item.time_ms;
          long_reported_nxt = 1'b0;
        end else if (!long_reported_r) begin
          button_event = EV_SHORT;
        end
      end
      // A release leaves the stable level low, so this check is skipped then.
      if (stable_level_nxt && !long_reported_nxt &&
          (lp_elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time})) begin
        long_reported_nxt = 1'b1;
        button_event      = EV_LONG;
      end
    end
  end

  // State update, once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_level_r     <= 1'b0;
      stable_level_r  <= 1'b0;
      change_time_r   <= '0;
      press_time_r    <= '0;
      long_reported_r <= 1'b0;
    end else if (en) begin
      raw_level_r     <= raw_level_nxt;
      stable_level_r  <= stable_level_nxt;
      change_time_r   <= change_time_nxt;
      press_time_r    <= press_time_nxt;
      long_reported_r <= long_reported_nxt;
    end
  end

  // A long press leaves the button held and marked as reported.
  a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
    en && (button_event == EV_LONG) |=> stable_level_r && long_reported_r)
    else $error("long press did not leave a held, reported state");

  // A short press is only given on a debounced release.
  a_short_release: assert property (@(posedge clk) disable iff (!rst_n)
    en && (button_event == EV_SHORT) |=> !stable_level_r && !raw_level_r)
    else $error("short press without a debounced release");

  // A start item loads matching levels and clears the long-press mark.
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    en && (item.action == ACT_START) |=>
      (stable_level_r == raw_level_r) && !long_reported_r &&
      (press_time_r == change_time_r))
    else $error("start item did not load the initial state");

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_long_press_unit.sv =====
// Button debounce and long-press unit: input register, core logic, result register.
// A result passes the input register and then the result register before it is on out_*.
// Throughput: one item per cycle while out_stall is low; bdlp_core updates its state once per item.
// Reset: synchronous active-low rst_n clears both valid flags and the button state
// and loads debounce_time 25 and long_press_time 700. No clearing pass is needed.
`default_nettype none

module button_debounce_long_press_unit
  import bdlp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_action,
  input  wire logic                 in_pressed_level,
  input  wire logic [TIME_W-1:0]    in_time_ms,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_button_event,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic   s1_valid_r;
  item_t  s1_item_r;
  logic   out_valid_r;
  event_t out_event_r;
  event_t core_event;
  cfg_t   cfg;
  logic   out_free;
  logic   advance;
  logic   in_take;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  bdlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Pipeline flow: the input stage moves on whenever the result register
  // is empty or being drained in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.action        <= in_action;
      s1_item_r.pressed_level <= in_pressed_level;
      s1_item_r.time_ms       <= in_time_ms;
    end
  end

  // Per-item logic and button state.
  bdlp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .item         (s1_item_r),
    .cfg          (cfg),
    .button_event (core_event)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= core_event;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_event = out_event_r;

  // A held input item is never dropped while the result side is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost an item under stall");

  // Every item that leaves the input stage shows up as a result.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item did not reach the result register");

  // A stalled result is neither replaced nor dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_event_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/bdlp_event_checker.sv =====
// Button event checker: watches the input, result and configuration transfers of the
// debounce and long-press unit, predicts each button event and compares it on arrival.
// Depends on bdlp_pkg for field widths, register indexes, action and event codes.
`timescale 1ns / 1ps

module bdlp_event_checker
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_action,
  input  logic                 in_pressed_level,
  input  logic [TIME_W-1:0]    in_time_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_button_event,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatch_count,
  output int                   pending_events
);

  // Predicted timing settings.
  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  hold_ms;

  // Predicted button state.
  logic              raw_seen;
  logic              settled_level;
  logic [TIME_W-1:0] toggle_ms;
  logic [TIME_W-1:0] press_start_ms;
  logic              long_sent;

  // Button events still owed by the block, oldest first.
  event_t            owed_events[$];
  int                errors;

  // Advances the button state by one input item and returns the event it causes.
  function automatic event_t next_button_event(input logic act, input logic lvl,
                                               input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since_toggle;
    logic [TIME_W-1:0] since_press;
    if (act == ACT_START) begin
      raw_seen       = lvl;
      settled_level  = lvl;
      toggle_ms      = now;
      press_start_ms = now;
      long_sent      = 1'b0;
      return EV_NONE;
    end
    if (lvl != raw_seen) begin
      raw_seen  = lvl;
      toggle_ms = now;
    end
    // Accept the raw level once it has held for the debounce time.
    since_toggle = now - toggle_ms;
    if (settled_level != raw_seen && since_toggle >= TIME_W'(debounce_ms)) begin
      settled_level = raw_seen;
      if (settled_level) begin
        press_start_ms = now;
        long_sent      = 1'b0;
      end else if (!long_sent) begin
        return EV_SHORT;
      end else begin
        return EV_NONE;
      end
    end
    // A held press reports its long press exactly once.
    since_press = now - press_start_ms;
    if (settled_level && !long_sent && since_press >= TIME_W'(hold_ms)) begin
      long_sent = 1'b1;
      return EV_LONG;
    end
    return EV_NONE;
  endfunction

  // Track every transfer on the rising edge; payloads are stable there.
  always @(posedge clk) begin
    event_t want;
    if (!rst_n) begin
      debounce_ms    = DEBOUNCE_RST;
      hold_ms        = LONG_PRESS_RST;
      raw_seen       = 1'b0;
      settled_level  = 1'b0;
      toggle_ms      = '0;
      press_start_ms = '0;
      long_sent      = 1'b0;
      owed_events.delete();
      errors         = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_DEBOUNCE:   debounce_ms = cfg_wdata;
          CFG_IDX_LONG_PRESS: hold_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_events.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected button_event %0d, no result pending",
                     $time, out_button_event);
          errors++;
        end else begin
          want = owed_events.pop_front();
          if (out_button_event !== want) begin
            if (errors < 10)
              $display("%0t: button_event expected %0d, actual %0d",
                       $time, want, out_button_event);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        owed_events.push_back(next_button_event(in_action, in_pressed_level, in_time_ms));
    end
    mismatch_count <= errors;
    pending_events <= owed_events.size();
  end

endmodule

// ===== dv/button_debounce_long_press_unit_tb.sv =====
// Testbench top for the button debounce and long-press unit: clock, reset, stimulus,
// random idling on both channels and the verdict. Depends on bdlp_pkg and bdlp_event_checker.
`timescale 1ns / 1ps

module button_debounce_long_press_unit_tb;
  import bdlp_pkg::*;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int TIMEOUT_NS    = 2_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_action = ACT_SAMPLE;
  logic                 in_pressed_level = 1'b0;
  logic [TIME_W-1:0]    in_time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_button_event;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   mismatch_count;
  int                   pending_events;

  // Stimulus state: percentages of idle cycles, the button clock and the settings.
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   items_sent = 0;
  logic [TIME_W-1:0]    clock_ms = '0;
  int unsigned          debounce_set = 32'(DEBOUNCE_RST);
  int unsigned          long_set = 32'(LONG_PRESS_RST);

  always #1 clk = ~clk;

  button_debounce_long_press_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_pressed_level(in_pressed_level), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_button_event(out_button_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  bdlp_event_checker events_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_pressed_level(in_pressed_level), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_button_event(out_button_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .pending_events(pending_events)
  );

  // The result side stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Presents one item and returns at the edge of its transfer. Valid stays high into
  // the next item unless an idle gap is taken first.
  task automatic drive_item(input logic act, input logic lvl, input logic [TIME_W-1:0] t);
    logic took;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_pressed_level <= lvl;
    in_time_ms       <= t;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic sample_after(input logic lvl, input int unsigned dt);
    clock_ms = clock_ms + dt;
    drive_item(ACT_SAMPLE, lvl, clock_ms);
  endtask

  task automatic start_after(input logic lvl, input int unsigned dt);
    clock_ms = clock_ms + dt;
    drive_item(ACT_START, lvl, clock_ms);
  endtask

  // Stops the sender and waits until every owed event has arrived and the pipe is empty.
  task automatic drain_events();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_events != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both timing registers and the two undecoded indexes, back to back.
  task automatic program_timing(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    logic                 took;
    idx[0] = CFG_IDX_SPARE_A;
    idx[1] = CFG_IDX_DEBOUNCE;
    idx[2] = CFG_IDX_SPARE_B;
    idx[3] = CFG_IDX_LONG_PRESS;
    val[0] = CFG_W'($urandom());
    val[1] = db;
    val[2] = CFG_W'($urandom());
    val[3] = lp;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
    end
    cfg_valid <= 1'b0;
    debounce_set = 32'(db);
    long_set     = 32'(lp);
  endtask

  // One press and release with bounce on both edges; the hold lands on either side
  // of the long-press threshold.
  task automatic play_press_cycle();
    int unsigned settle;
    int unsigned hold;
    int unsigned steps;
    settle = debounce_set + 1;
    repeat ($urandom_range(0, 3)) begin
      sample_after(1'b1, $urandom_range(0, settle));
      sample_after(1'b0, $urandom_range(0, settle));
    end
    if ($urandom_range(1))
      hold = $urandom_range(0, long_set);
    else
      hold = long_set + $urandom_range(0, long_set / 2 + 4);
    steps = $urandom_range(1, 5);
    sample_after(1'b1, $urandom_range(0, 3));
    repeat (steps) sample_after(1'b1, $urandom_range(0, 2 * ((settle + hold) / steps) + 1));
    repeat ($urandom_range(0, 3)) begin
      sample_after(1'b0, $urandom_range(0, settle));
      sample_after(1'b1, $urandom_range(0, settle));
    end
    sample_after(1'b0, $urandom_range(0, 3));
    repeat (steps) sample_after(1'b0, $urandom_range(0, 2 * (settle / steps) + 1));
  endtask

  // Random part of a phase: mostly clean press cycles, some noise, restarts and jumps.
  task automatic run_random_items(input int goal);
    int pick;
    start_after(1'($urandom_range(1)), $urandom_range(0, 100));
    while (items_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        clock_ms = $urandom();
      end else if (pick == 1) begin
        start_after(1'($urandom_range(1)), $urandom_range(0, 1000));
      end else if (pick < 5) begin
        drive_item(($urandom_range(0, 7) == 0) ? ACT_START : ACT_SAMPLE,
                   1'($urandom_range(1)),
                   $urandom_range(1) ? $urandom() : clock_ms + $urandom_range(0, 64));
      end else begin
        play_press_cycle();
      end
    end
  endtask

  // Main sequence: reset, directed items, then phases of settings and idling.
  initial begin
    int goal;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings of 25 ms and 700 ms.
    drive_item(ACT_START, 1'b0, 32'd0);
    drive_item(ACT_SAMPLE, 1'b1, 32'd10);
    drive_item(ACT_SAMPLE, 1'b0, 32'd15);
    drive_item(ACT_SAMPLE, 1'b1, 32'd20);
    drive_item(ACT_SAMPLE, 1'b1, 32'd44);
    drive_item(ACT_SAMPLE, 1'b1, 32'd45);
    drive_item(ACT_SAMPLE, 1'b1, 32'd744);
    drive_item(ACT_SAMPLE, 1'b1, 32'd745);
    drive_item(ACT_SAMPLE, 1'b1, 32'd2000);
    // Release after a long press gives no short press.
    drive_item(ACT_SAMPLE, 1'b0, 32'd2001);
    drive_item(ACT_SAMPLE, 1'b0, 32'd2026);
    // Short press reported in the sample that accepts the release.
    drive_item(ACT_SAMPLE, 1'b1, 32'd3000);
    drive_item(ACT_SAMPLE, 1'b1, 32'd3025);
    drive_item(ACT_SAMPLE, 1'b0, 32'd3100);
    drive_item(ACT_SAMPLE, 1'b0, 32'd3125);
    // Start while pressed just before the timestamp wraps; long press across the wrap.
    drive_item(ACT_START, 1'b1, 32'hFFFF_FFF0);
    drive_item(ACT_SAMPLE, 1'b1, 32'h0000_02AB);
    drive_item(ACT_SAMPLE, 1'b1, 32'h0000_02AC);
    drive_item(ACT_START, 1'b0, 32'hFFFF_FFFF);
    drive_item(ACT_SAMPLE, 1'b0, 32'h0000_0000);

    goal = items_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_events();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 70; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 70; end
        default: begin idle_pct = 10; stall_pct <= 10; end
      endcase
      case (phase)
        0: program_timing(DEBOUNCE_RST, LONG_PRESS_RST);
        1: program_timing(16'd0, 16'd0);
        2: program_timing(16'hFFFF, 16'hFFFF);
        3: program_timing(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 900)));
        4: program_timing(16'd0, 16'hFFFF);
        5: program_timing(16'hFFFF, 16'd0);
        6: program_timing(CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 300)));
        default: program_timing(CFG_W'($urandom()), CFG_W'($urandom()));
      endcase
      if (phase == 1) begin
        // Zero debounce and zero long-press time: acceptance and long press at once.
        start_after(1'b0, 5);
        sample_after(1'b1, 0);
        sample_after(1'b0, 1);
        sample_after(1'b1, 1);
        start_after(1'b1, 1);
        sample_after(1'b1, 0);
      end
      goal = goal + ITEMS_PER_PHASE;
      run_random_items(goal);
    end

    drain_events();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending_events == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== button_debounce_long_press_unit.f =====
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_cfg.sv
hw/rtl/bdlp_core.sv
hw/rtl/button_debounce_long_press_unit.sv
dv/bdlp_event_checker.sv
dv/button_debounce_long_press_unit_tb.sv
